/* rtl/core/nmo_pkg.sv */
// ----------------------------------------------------------------------------
// NMO package
// Shared constants, widths and transaction types of the NMO correction block.
// ----------------------------------------------------------------------------
package nmo_pkg;

   localparam int MAX_SAMPLES   = 2048;
   localparam int SAMPLE_BITS   = 24;
   localparam int FRACTION_BITS = 16;

   localparam int IDX_W  = 11;
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int LEN_W  = 12;
   localparam int OFF_W  = 12;
   localparam int DT_W   = 16;
   localparam int VEL_W  = 14;

   // offset term: q = (x * 2e6) << F / (v * dt)
   localparam longint USEC_SCALE = 2000000;
   localparam int DEN_W  = VEL_W + DT_W;
   localparam int NUMB_W = OFF_W + 21;
   localparam int NUM_W  = NUMB_W + FRACTION_BITS;
   localparam int Q_W    = LEN_W + FRACTION_BITS;
   localparam int R_W    = Q_W;
   localparam int RAD_W  = 2 * R_W;

   localparam int PIPE_DEPTH = Q_W + R_W + 8;
   localparam int PEND_W     = $clog2(PIPE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_TRACE_LENGTH = 2'd0;
   localparam logic [1:0] REG_OFFSET       = 2'd1;
   localparam logic [1:0] REG_INTERVAL     = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic                          action;
      logic [IDX_W-1:0]              time_index;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [VEL_W-1:0]              rms_velocity;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] corrected_sample;
      logic                          in_range;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             zoff;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

/* rtl/core/nmo_div.sv */
// ----------------------------------------------------------------------------
// NMO divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module nmo_div import nmo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  tag_type          in_tag,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output tag_type          out_tag,
   output logic [Q_W-1:0]   out_q
);

   tag_type          tag_ff [Q_W];
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   lo_ff  [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      tag_type          tag_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   lo_prev;
      logic [Q_W-1:0]   q_prev;
      logic [DEN_W:0]   sh;
      logic             ge;

      if (k == 0) begin : g_first
         assign tag_prev = in_tag;
         assign rem_prev = DEN_W'(in_num[NUM_W-1:Q_W]);
         assign den_prev = in_den;
         assign lo_prev  = in_num[Q_W-1:0];
         assign q_prev   = '0;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      assign sh = {rem_prev, lo_prev[Q_W-1]};
      assign ge = (sh >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            tag_ff[k].valid <= tag_prev.valid;
         end
         if (en) begin
            tag_ff[k].ok   <= tag_prev.ok;
            tag_ff[k].zoff <= tag_prev.zoff;
            tag_ff[k].idx  <= tag_prev.idx;
            rem_ff[k]      <= ge ? DEN_W'(sh - {1'b0, den_prev}) : DEN_W'(sh);
            den_ff[k]      <= den_prev;
            lo_ff[k]       <= {lo_prev[Q_W-2:0], 1'b0};
            q_ff[k]        <= {q_prev[Q_W-2:0], ge};
         end
      end
   end

   assign out_tag = tag_ff[Q_W-1];
   assign out_q   = q_ff[Q_W-1];

endmodule

/* rtl/core/nmo_sqrt.sv */
// ----------------------------------------------------------------------------
// NMO square root
// Digit-by-digit integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module nmo_sqrt import nmo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  tag_type          in_tag,
   input  logic [RAD_W-1:0] in_rad,
   output tag_type          out_tag,
   output logic [R_W-1:0]   out_root
);

   localparam int REM_W = R_W + 2;

   tag_type          tag_ff  [R_W];
   logic [REM_W-1:0] rem_ff  [R_W];
   logic [R_W-1:0]   root_ff [R_W];
   logic [RAD_W-1:0] rad_ff  [R_W];

   for (genvar k = 0; k < R_W; k++) begin : g_stage
      tag_type          tag_prev;
      logic [REM_W-1:0] rem_prev;
      logic [R_W-1:0]   root_prev;
      logic [RAD_W-1:0] rad_prev;
      logic [REM_W+1:0] sh;
      logic [REM_W+1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign tag_prev  = in_tag;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
      end else begin : g_next
         assign tag_prev  = tag_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign sh    = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
      assign trial = (REM_W+2)'({root_prev, 2'b01});
      assign ge    = (sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            tag_ff[k].valid <= tag_prev.valid;
         end
         if (en) begin
            tag_ff[k].ok   <= tag_prev.ok;
            tag_ff[k].zoff <= tag_prev.zoff;
            tag_ff[k].idx  <= tag_prev.idx;
            rem_ff[k]      <= ge ? REM_W'(sh - trial) : REM_W'(sh);
            root_ff[k]     <= {root_prev[R_W-2:0], ge};
            rad_ff[k]      <= {rad_prev[RAD_W-3:0], 2'b00};
         end
      end
   end

   assign out_tag  = tag_ff[R_W-1];
   assign out_root = root_ff[R_W-1];

endmodule

/* rtl/core/nmo_interp.sv */
// ----------------------------------------------------------------------------
// NMO interpolator
// Sample store, neighbour fetch, linear interpolation and output register.
// ----------------------------------------------------------------------------
module nmo_interp import nmo_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic [LEN_W-1:0]              len,
   input  tag_type                       in_tag,
   input  logic [R_W-1:0]                in_root,
   output logic                          rd_take,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data
);

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
   localparam int ACC_W  = SAMPLE_BITS + FRACTION_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_SAMPLES];

   logic [LEN_W-1:0]         n;
   logic [LEN_W:0]           n1;
   logic                     ok0;

   logic                          rd_valid_ff;
   logic                          rd_ok_ff;
   logic [FRACTION_BITS-1:0]      rd_frac_ff;
   logic signed [SAMPLE_BITS-1:0] s0_ff;
   logic signed [SAMPLE_BITS-1:0] s1_ff;

   logic signed [DIFF_W-1:0]      diff;
   logic                          mul_valid_ff;
   logic                          mul_ok_ff;
   logic signed [SAMPLE_BITS-1:0] mul_s0_ff;
   logic signed [PROD_W-1:0]      prod_ff;

   logic signed [ACC_W-1:0]       acc;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   assign n   = LEN_W'(in_root[R_W-1:FRACTION_BITS]);
   assign n1  = {1'b0, n} + (LEN_W+1)'(1);
   assign ok0 = in_tag.ok && (n1 < {1'b0, len});

   assign rd_take = en && in_tag.valid;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= wr_data;
      end
      if (en) begin
         s0_ff <= sample_mem[n[ADDR_W-1:0]];
         s1_ff <= sample_mem[n1[ADDR_W-1:0]];
      end
   end

   assign diff = DIFF_W'(s1_ff) - DIFF_W'(s0_ff);
   assign acc  = (ACC_W'(mul_s0_ff) <<< FRACTION_BITS) + ACC_W'(prod_ff)
                 + ACC_W'(1 << (FRACTION_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff  <= in_tag.valid;
         mul_valid_ff <= rd_valid_ff;
         rsp_valid_ff <= mul_valid_ff;
      end
      if (en) begin
         rd_ok_ff   <= ok0;
         rd_frac_ff <= in_root[FRACTION_BITS-1:0];
         mul_ok_ff  <= rd_ok_ff;
         mul_s0_ff  <= s0_ff;
         prod_ff    <= $signed({1'b0, rd_frac_ff}) * diff;
         rsp_data_ff.in_range         <= mul_ok_ff;
         rsp_data_ff.corrected_sample <= mul_ok_ff ?
                                         SAMPLE_BITS'(acc >>> FRACTION_BITS) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/nmo_correction_offset_domain_top.sv */
// ----------------------------------------------------------------------------
// NMO correction, offset domain
// Loads store a sample and its RMS velocity; queries return the trace value
// linearly interpolated at the moveout-stretched time.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while the output is not stalled
// and no load is held off. A query passes Q_W + R_W + 8 register stages (64
// at the default widths), the first loaded at the accepting edge: two setup
// stages, a 28-stage divider for the offset term, a range check stage, a
// squaring stage, a sum stage, a 28-stage square root, a sample fetch, a
// multiply stage and the output register. A stalled output freezes the whole
// pipeline. A load is held off while a query is in flight that has not yet
// fetched its samples, so a load right after a query waits until that query
// has reached the sample fetch, and longer if the output stalls.
module nmo_correction_offset_domain_top import nmo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0] trace_length_ff;
   logic [OFF_W-1:0] offset_ff;
   logic [DT_W-1:0]  interval_ff;
   logic [1:0]       csr_idx;
   logic             csr_wr;

   logic             en;
   logic             accept;
   logic [LEN_W-1:0] len;
   logic [PEND_W-1:0] pend_ff;
   logic [PEND_W-1:0] pend_in;
   logic             rd_take;

   logic [VEL_W-1:0] vel_mem [MAX_SAMPLES];
   logic [VEL_W-1:0] vel_rd_ff;
   tag_type          p0_tag_ff;

   logic [DEN_W-1:0]  den;
   logic [NUMB_W-1:0] num_base;
   logic [NUM_W-1:0]  num;
   logic              ok1;
   tag_type           p1_tag_ff;
   logic [DEN_W-1:0]  p1_den_ff;
   logic [NUM_W-1:0]  p1_num_ff;

   tag_type           div_tag;
   logic [Q_W-1:0]    div_q;
   logic [Q_W-1:0]    q;
   tag_type           p2_tag_ff;
   logic [Q_W-2:0]    p2_q_ff;
   tag_type           p3_tag_ff;
   logic [2*(Q_W-1)-1:0] p3_qsq_ff;
   logic [2*IDX_W-1:0]   p3_isq_ff;
   tag_type           p4_tag_ff;
   logic [RAD_W-1:0]  p4_rad_ff;

   tag_type           sq_tag;
   logic [R_W-1:0]    sq_root;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_length_ff <= LEN_W'(2048);
         offset_ff       <= '0;
         interval_ff     <= DT_W'(1000);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TRACE_LENGTH: trace_length_ff <= csr_pwdata[LEN_W-1:0];
            REG_OFFSET:       offset_ff       <= csr_pwdata[OFF_W-1:0];
            REG_INTERVAL:     interval_ff     <= csr_pwdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TRACE_LENGTH: csr_prdata = 32'(trace_length_ff);
         REG_OFFSET:       csr_prdata = 32'(offset_ff);
         REG_INTERVAL:     csr_prdata = 32'(interval_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // pipeline advance and input handshake
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !(req_data.action == ACT_LOAD && pend_ff != '0);
   assign accept    = req_valid && req_ready;
   assign len       = (trace_length_ff > LEN_W'(MAX_SAMPLES)) ?
                      LEN_W'(MAX_SAMPLES) : trace_length_ff;

   // count queries that have not yet fetched their samples
   always_comb begin
      pend_in = pend_ff;
      if (accept && req_data.action == ACT_QUERY) begin
         pend_in = pend_in + PEND_W'(1);
      end
      if (rd_take) begin
         pend_in = pend_in - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // velocity store
   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_LOAD) begin
         vel_mem[req_data.time_index[ADDR_W-1:0]] <= req_data.rms_velocity;
      end
      if (en) begin
         vel_rd_ff <= vel_mem[req_data.time_index[ADDR_W-1:0]];
      end
   end

   // offset term operands and early range checks
   assign den      = DEN_W'(vel_rd_ff) * DEN_W'(interval_ff);
   assign num_base = NUMB_W'(offset_ff) * NUMB_W'(USEC_SCALE);
   assign num      = {num_base, {FRACTION_BITS{1'b0}}};
   assign ok1      = ({1'b0, p0_tag_ff.idx} < len) &&
                     !(offset_ff != '0 &&
                       DEN_W'(num[NUM_W-1:Q_W]) >= den);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_tag_ff.valid <= 1'b0;
         p1_tag_ff.valid <= 1'b0;
         p2_tag_ff.valid <= 1'b0;
         p3_tag_ff.valid <= 1'b0;
         p4_tag_ff.valid <= 1'b0;
      end else if (en) begin
         p0_tag_ff.valid <= accept && req_data.action == ACT_QUERY;
         p1_tag_ff.valid <= p0_tag_ff.valid;
         p2_tag_ff.valid <= div_tag.valid;
         p3_tag_ff.valid <= p2_tag_ff.valid;
         p4_tag_ff.valid <= p3_tag_ff.valid;
      end
      if (en) begin
         p0_tag_ff.ok   <= 1'b1;
         p0_tag_ff.zoff <= 1'b0;
         p0_tag_ff.idx  <= req_data.time_index;

         p1_tag_ff.ok   <= ok1;
         p1_tag_ff.zoff <= (offset_ff == '0);
         p1_tag_ff.idx  <= p0_tag_ff.idx;
         p1_den_ff      <= den;
         p1_num_ff      <= num;

         p2_tag_ff.ok   <= div_tag.ok && (q[Q_W-1:FRACTION_BITS] < len);
         p2_tag_ff.zoff <= div_tag.zoff;
         p2_tag_ff.idx  <= div_tag.idx;
         p2_q_ff        <= q[Q_W-2:0];

         p3_tag_ff.ok   <= p2_tag_ff.ok;
         p3_tag_ff.zoff <= p2_tag_ff.zoff;
         p3_tag_ff.idx  <= p2_tag_ff.idx;
         p3_qsq_ff      <= (2*(Q_W-1))'(p2_q_ff) * (2*(Q_W-1))'(p2_q_ff);
         p3_isq_ff      <= (2*IDX_W)'(p2_tag_ff.idx) * (2*IDX_W)'(p2_tag_ff.idx);

         p4_tag_ff      <= p3_tag_ff;
         p4_rad_ff      <= RAD_W'({p3_isq_ff, {(2*FRACTION_BITS){1'b0}}})
                           + RAD_W'(p3_qsq_ff);
      end
   end

   nmo_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (p1_tag_ff),
      .in_num  (p1_num_ff),
      .in_den  (p1_den_ff),
      .out_tag (div_tag),
      .out_q   (div_q)
   );

   // zero offset gives no moveout whatever the velocity
   assign q = div_tag.zoff ? '0 : div_q;

   nmo_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_tag   (p4_tag_ff),
      .in_rad   (p4_rad_ff),
      .out_tag  (sq_tag),
      .out_root (sq_root)
   );

   nmo_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .wr_en     (accept && req_data.action == ACT_LOAD),
      .wr_addr   (req_data.time_index[ADDR_W-1:0]),
      .wr_data   (req_data.sample_value),
      .len       (len),
      .in_tag    (sq_tag),
      .in_root   (sq_root),
      .rd_take   (rd_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_load_waits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACT_LOAD) |-> (pend_ff == '0))
      else $error("load accepted with queries in flight");

   a_take_counted: assert property (@(posedge clock) disable iff (reset)
      rd_take |-> (pend_ff != '0))
      else $error("sample fetch without a pending query");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_range) |-> (rsp_data.corrected_sample == '0))
      else $error("out-of-range result is not zero");
`endif

endmodule

/* tb/nmo_correction_offset_domain_top_tb.sv */
// ----------------------------------------------------------------------------
// NMO correction testbench
// Fills the low part of the trace store, then runs query and load traffic
// under several register settings; every result is checked against an
// in-bench predictor of the moveout-stretched, linearly interpolated sample.
// ----------------------------------------------------------------------------
module nmo_correction_offset_domain_top_tb;
   import nmo_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int FILL_COUNT     = 400;
   localparam int SAFE_TRIES     = 20;

   class nmo_scoreboard;
      logic signed [SAMPLE_BITS-1:0] sample_mem[MAX_SAMPLES];
      logic [VEL_W-1:0]              velocity_mem[MAX_SAMPLES];
      bit                            written[MAX_SAMPLES];
      bit                            unsafe    = 1'b0;
      logic [LEN_W-1:0]              trace_len = 12'd2048;
      logic [OFF_W-1:0]              offset_m  = '0;
      logic [DT_W-1:0]               dt_us     = 16'd1000;
      rsp_type                       expected_q[$];
      int                            errors    = 0;

      function void set_reg(logic [1:0] index, logic [31:0] value);
         if (index == REG_TRACE_LENGTH) trace_len = value[LEN_W-1:0];
         else if (index == REG_OFFSET) offset_m = value[OFF_W-1:0];
         else if (index == REG_INTERVAL) dt_us = value[DT_W-1:0];
      endfunction

      function longint unsigned root_floor(longint unsigned x);
         longint unsigned r, c;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
         end
         return r;
      endfunction

      // also flags a query that would read an entry never loaded
      function rsp_type stretch_sample(int idx);
         rsp_type         res;
         int              len;
         bit              ok;
         longint unsigned q, den, it, tau, n, frac;
         longint          s0, s1, acc, val;
         len = (trace_len < MAX_SAMPLES) ? int'(trace_len) : MAX_SAMPLES;
         ok  = idx < len;
         q   = 0;
         res = '0;
         unsafe = !written[idx];
         if (ok && offset_m != 0) begin
            den = longint'(velocity_mem[idx]) * longint'(dt_us);
            if (den == 0) ok = 0;
            else begin
               q = ((64'd2 * offset_m * 64'd1000000) << FRACTION_BITS) / den;
               if ((q >> FRACTION_BITS) >= len) ok = 0;
            end
         end
         if (ok) begin
            it   = longint'(idx) << FRACTION_BITS;
            tau  = root_floor(it * it + q * q);
            n    = tau >> FRACTION_BITS;
            frac = tau & ((64'd1 << FRACTION_BITS) - 1);
            if (n + 1 >= len) ok = 0;
            else begin
               if (!written[n] || !written[n + 1]) unsafe = 1'b1;
               s0  = longint'(sample_mem[n]);
               s1  = longint'(sample_mem[n + 1]);
               acc = s0 * (64'sd1 <<< FRACTION_BITS) + longint'(frac) * (s1 - s0);
               val = (acc + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
               res.corrected_sample = val[SAMPLE_BITS-1:0];
               res.in_range = 1'b1;
            end
         end
         return res;
      endfunction

      function bit query_safe(int idx);
         void'(stretch_sample(idx));
         return !unsafe;
      endfunction

      function void note_input(req_type r);
         if (r.action == ACT_LOAD) begin
            sample_mem[r.time_index]   = r.sample_value;
            velocity_mem[r.time_index] = r.rms_velocity;
            written[r.time_index]      = 1'b1;
         end else
            expected_q.push_back(stretch_sample(int'(r.time_index)));
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         exp = expected_q.pop_front();
         if (got.corrected_sample !== exp.corrected_sample)
            report($sformatf("corrected_sample %0d, predicted %0d",
                             got.corrected_sample, exp.corrected_sample));
         if (got.in_range !== exp.in_range)
            report($sformatf("in_range %b, predicted %b", got.in_range, exp.in_range));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   nmo_scoreboard sb = new();
   bit            calm = 1'b0;
   int            quiet_cycles = 0;

   nmo_correction_offset_domain_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
         if (req_valid && req_ready) sb.note_input(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // count cycles with no transaction or register access
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task send(req_type d);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_load(int idx, logic [SAMPLE_BITS-1:0] val, logic [VEL_W-1:0] vel);
      req_type d;
      d.action       = ACT_LOAD;
      d.time_index   = idx[IDX_W-1:0];
      d.sample_value = val;
      d.rms_velocity = vel;
      send(d);
   endtask

   task send_query(int idx);
      req_type d;
      d.action       = ACT_QUERY;
      d.time_index   = idx[IDX_W-1:0];
      d.sample_value = SAMPLE_BITS'($urandom());
      d.rms_velocity = VEL_W'($urandom());
      send(d);
   endtask

   // hold the sender until every result is in, then let loads settle
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * index);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(index, value);
      @(posedge clock);
   endtask

   task configure(int len, int off, int dt);
      csr_write(REG_TRACE_LENGTH, {20'($urandom_range(1048575)), len[11:0]});
      csr_write(REG_OFFSET, {20'($urandom_range(1048575)), off[11:0]});
      csr_write(REG_INTERVAL, {16'($urandom_range(65535)), dt[15:0]});
   endtask

   function logic [VEL_W-1:0] pick_velocity();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return '0;
      if (sel < 20) return VEL_W'($urandom_range(1, 50));
      if (sel < 60) return VEL_W'($urandom_range(1500, 6000));
      return VEL_W'($urandom_range(1, 16383));
   endfunction

   // skip queries that would read a never-loaded entry; load instead
   task random_phase(int count);
      int len, idx, tries;
      bit found;
      len = (sb.trace_len < MAX_SAMPLES) ? int'(sb.trace_len) : MAX_SAMPLES;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 15)
            send_load($urandom_range(MAX_SAMPLES - 1), SAMPLE_BITS'($urandom()),
                      pick_velocity());
         else begin
            found = 1'b0;
            tries = 0;
            while (!found && tries < SAFE_TRIES) begin
               if (len > 0 && $urandom_range(99) < 85) idx = $urandom_range(len - 1);
               else idx = $urandom_range(MAX_SAMPLES - 1);
               found = sb.query_safe(idx);
               tries++;
            end
            if (found) send_query(idx);
            else send_load($urandom_range(MAX_SAMPLES - 1), SAMPLE_BITS'($urandom()),
                           pick_velocity());
         end
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the low part of the store and the last two entries
      for (int k = 0; k < FILL_COUNT; k++) begin
         if (k == 0) send_load(k, 24'h7FFFFF, 14'h3FFF);
         else if (k == 1) send_load(k, 24'h800000, 14'd1);
         else send_load(k, SAMPLE_BITS'($urandom()), pick_velocity());
      end
      send_load(MAX_SAMPLES - 2, SAMPLE_BITS'($urandom()), pick_velocity());
      send_load(MAX_SAMPLES - 1, 24'h800000, 14'h2AAA);
      drain();

      // directed: edges of index at default settings, then extreme neighbors
      send_query(0);
      send_query(1);
      send_query(2046);
      send_query(2047);
      send_load(5, 24'h7FFFFF, 14'h1555);
      send_load(6, 24'h800000, 14'd0);
      send_query(5);
      send_query(6);
      drain();
      configure(12, 4095, 1);
      send_query(5);
      send_query(6);
      drain();
      configure(300, 100, 1000);
      send_query(6);
      send_query(5);
      send_query(299);
      send_query(300);
      drain();
      // register index past the list must be ignored
      csr_write(2'd3, 32'hFFFF_FFFF);
      send_query(7);
      drain();

      calm = 1'b1;
      configure(2048, 100, 1000);
      random_phase(100);
      calm = 1'b0;
      configure(4095, 4095, 65535);
      random_phase(100);
      configure(2, 0, 1000);
      random_phase(60);
      configure(1, 0, 7);
      random_phase(40);
      configure(0, 0, 7);
      random_phase(40);
      configure(300, 1, 1);
      random_phase(80);
      configure(2048, 7, 0);
      random_phase(60);
      configure(1000, 37, 4000);
      random_phase(130);
      configure(2048, 0, 1000);
      random_phase(100);
      configure(1500, 2500, 20000);
      random_phase(100);

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/nmo_pkg.sv
rtl/core/nmo_div.sv
rtl/core/nmo_sqrt.sv
rtl/core/nmo_interp.sv
rtl/core/nmo_correction_offset_domain_top.sv
tb/nmo_correction_offset_domain_top_tb.sv
